/* rtl/core/tpc_pkg.sv */
`timescale 1ns / 1ps
package tpc_pkg;
  localparam int unsigned FracBitsDefault = 16;
  localparam int unsigned CfgW = 11;

  // v*15/100 and v*85/100 as (v * k) >> 24 with k = 15 or 85 times 167773
  localparam logic [31:0] Pct15Mul = 32'd2516595;
  localparam logic [31:0] Pct85Mul = 32'd14260705;
  // last microcode step before the divides
  localparam logic [5:0]  LastStep = 6'd33;

  typedef enum logic [1:0] {
    REG_WIDTH    = 2'd0,
    REG_HEIGHT   = 2'd1,
    REG_HORZ_OFS = 2'd2,
    REG_VERT_OFS = 2'd3
  } cfg_reg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIVSTART,
    ST_DIVWAIT,
    ST_EMIT
  } state_e;

  // divider control/status
  typedef struct packed {
    logic        start;
    logic [63:0] dividend;
    logic [31:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] quotient;
  } div_rsp_t;
endpackage

/* rtl/core/tpc_div.sv */
`timescale 1ns / 1ps
// Signed 64 / 32 restoring divider, one quotient bit per cycle, truncates toward zero.
module tpc_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  tpc_pkg::div_req_t req_i,
  output tpc_pkg::div_rsp_t rsp_o
);
  logic [63:0] quo_q, quo_d;
  logic [32:0] rem_q, rem_d;
  logic [31:0] dvs_q, dvs_d;
  logic [6:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d, neg_q, neg_d, done_q, done_d;
  logic [32:0] trial;
  logic [63:0] qneg;

  always_comb begin
    quo_d  = quo_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    neg_d  = neg_q;
    done_d = 1'b0;
    trial  = {rem_q[31:0], quo_q[63]} - {1'b0, dvs_q};
    if (req_i.start) begin
      quo_d  = req_i.dividend[63] ? (~req_i.dividend + 64'd1) : req_i.dividend;
      dvs_d  = req_i.divisor[31] ? (~req_i.divisor + 32'd1) : req_i.divisor;
      neg_d  = req_i.dividend[63] ^ req_i.divisor[31];
      rem_d  = '0;
      cnt_d  = 7'd64;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (!trial[32]) begin
        rem_d = trial;
        quo_d = {quo_q[62:0], 1'b1};
      end else begin
        rem_d = {rem_q[31:0], quo_q[63]};
        quo_d = {quo_q[62:0], 1'b0};
      end
      cnt_d = cnt_q - 7'd1;
      if (cnt_q == 7'd1) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
    neg_q <= neg_d;
  end

  assign qneg = ~quo_q + 64'd1;
  assign rsp_o.done = done_q;
  assign rsp_o.quotient = neg_q ? qneg[31:0] : quo_q[31:0];

  busy_count_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> cnt_q != 7'd0) else $error("divider busy with zero count");
  done_idle_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !busy_q) else $error("divider done while busy");
  start_busy_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.start |=> busy_q) else $error("divider did not start");
endmodule

/* rtl/core/touch_three_point_calibration_top.sv */
`timescale 1ns / 1ps
// Three-point touch calibration.
// Input channel: a reading transfers when start_i is high and busy_o is low.
// Readings with pen_up_i set are dropped. The third valid reading starts the
// solve; earlier readings leave busy_o low.
// Output channel: six coefficients A..F, each on the result ports for one
// cycle with valid_o high; last_o marks F. degenerate_o flags a zero
// determinant, and the value is then 0. The receiver cannot stall; results
// simply appear.
// Sequence: one shared 32x32 multiply-add runs 34 steps (6 for the targets,
// 2 for the determinant, 26 for the numerators), then each coefficient in
// turn passes the shared bit-serial divider (start, quotient bits, done,
// emit) and is put on the ports. With a zero determinant the divider result
// is not awaited: each coefficient goes from start straight to emit. busy_o
// is high until F is presented, so the next reading can transfer in F's cycle.
// Configuration: cfg_we_i, cfg_index_i, cfg_data_i, written while idle.
// Reset restores 800x480 and zero offsets, and clears the sample count.
module touch_three_point_calibration_top #(
  parameter int unsigned FRACTION_BITS = tpc_pkg::FracBitsDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic        pen_up_i,
  input  logic [9:0]  raw_x_i,
  input  logic [9:0]  raw_y_i,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [10:0] cfg_data_i,
  output logic        valid_o,
  output logic [2:0]  coef_index_o,
  output logic signed [31:0] coef_value_o,
  output logic        degenerate_o,
  output logic        last_o
);
  logic [10:0] w_q, h_q, ho_q, vo_q;
  logic [9:0]  sx_q [3];
  logic [9:0]  sy_q [3];
  logic [1:0]  cnt_q;
  tpc_pkg::state_e st_q, st_d;
  logic [5:0]  step_q, step_d;
  logic [2:0]  ci_q, ci_d;
  // scratch: 0..2 dx, 3..5 dy, 6 det, 7 offset sum, 8 offset inner term,
  // 9..14 numerators A..F
  logic [31:0] r_q [15];
  logic [31:0] ma, mb, madd, term, acc_d;
  logic        msub, mscl;
  logic [55:0] prod;
  logic [3:0]  dst;
  logic        wen;
  logic        accept;
  tpc_pkg::div_req_t dreq;
  tpc_pkg::div_rsp_t drsp;
  logic [31:0] num_sel;
  logic        det_zero;
  logic        out_v_q;
  logic [31:0] out_val_q;
  logic [2:0]  out_idx_q;
  logic        out_deg_q;

  assign accept = start_i && !busy_o;
  assign busy_o = (st_q != tpc_pkg::ST_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      w_q <= 11'd800; h_q <= 11'd480; ho_q <= '0; vo_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        tpc_pkg::REG_WIDTH:    w_q  <= cfg_data_i;
        tpc_pkg::REG_HEIGHT:   h_q  <= cfg_data_i;
        tpc_pkg::REG_HORZ_OFS: ho_q <= cfg_data_i;
        tpc_pkg::REG_VERT_OFS: vo_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && !pen_up_i) begin
      sx_q[cnt_q] <= raw_x_i;
      sy_q[cnt_q] <= raw_y_i;
    end
  end

  // Microcode for the shared multiply-add: acc = madd +/- term, term = ma*mb,
  // or (ma*mb) >> 24 for the percent targets (exact while v*85 < 199728).
  // Steps 8..20 build the x numerators, 21..33 the same for y.
  always_comb begin
    logic [31:0] tx0, tx1, tx2, ty0, ty1, ty2;
    logic [31:0] d0, d1, d2;
    logic [3:0]  base;
    logic        isy;
    logic [5:0]  u;
    tx0 = {22'd0, sx_q[0]}; tx1 = {22'd0, sx_q[1]}; tx2 = {22'd0, sx_q[2]};
    ty0 = {22'd0, sy_q[0]}; ty1 = {22'd0, sy_q[1]}; ty2 = {22'd0, sy_q[2]};
    isy  = (step_q >= 6'd21);
    u    = isy ? (step_q - 6'd21) : (step_q - 6'd8);
    d0   = isy ? r_q[3] : r_q[0];
    d1   = isy ? r_q[4] : r_q[1];
    d2   = isy ? r_q[5] : r_q[2];
    base = isy ? 4'd12 : 4'd9;
    ma = '0; mb = '0; madd = '0; msub = 1'b0; mscl = 1'b0; dst = '0; wen = 1'b0;
    if (step_q < 6'd8) begin
      wen = 1'b1;
      case (step_q)
        6'd0: begin ma = {21'd0, w_q}; mb = tpc_pkg::Pct15Mul; madd = {21'd0, ho_q};
                    mscl = 1'b1; dst = 4'd0; end
        6'd1: begin ma = {21'd0, w_q}; mb = tpc_pkg::Pct85Mul; madd = {21'd0, ho_q};
                    mscl = 1'b1; dst = 4'd1; end
        6'd2: begin ma = {22'd0, w_q[10:1]}; mb = 32'd1; madd = {21'd0, ho_q};
                    dst = 4'd2; end
        6'd3: begin ma = {21'd0, h_q}; mb = tpc_pkg::Pct15Mul; madd = {21'd0, vo_q};
                    mscl = 1'b1; dst = 4'd3; end
        6'd4: begin ma = {22'd0, h_q[10:1]}; mb = 32'd1; madd = {21'd0, vo_q};
                    dst = 4'd4; end
        6'd5: begin ma = {21'd0, h_q}; mb = tpc_pkg::Pct85Mul; madd = {21'd0, vo_q};
                    mscl = 1'b1; dst = 4'd5; end
        6'd6: begin ma = tx0 - tx2; mb = ty1 - ty2; dst = 4'd6; end
        6'd7: begin ma = tx1 - tx2; mb = ty0 - ty2; madd = r_q[6]; msub = 1'b1;
                    dst = 4'd6; end
        default: wen = 1'b0;
      endcase
    end else begin
      wen = 1'b1;
      case (u)
        6'd0:  begin ma = d0 - d2; mb = ty1 - ty2; dst = base; end
        6'd1:  begin ma = d1 - d2; mb = ty0 - ty2; madd = r_q[base]; msub = 1'b1;
                     dst = base; end
        6'd2:  begin ma = tx0 - tx2; mb = d1 - d2; dst = base + 4'd1; end
        6'd3:  begin ma = d0 - d2; mb = tx1 - tx2; madd = r_q[base + 4'd1];
                     msub = 1'b1; dst = base + 4'd1; end
        // offset term: ty0*(tx2*d1 - tx1*d2) + ty1*(tx0*d2 - tx2*d0)
        //            + ty2*(tx1*d0 - tx0*d1)
        6'd4:  begin ma = tx2; mb = d1; dst = 4'd8; end
        6'd5:  begin ma = tx1; mb = d2; madd = r_q[8]; msub = 1'b1; dst = 4'd8; end
        6'd6:  begin ma = ty0; mb = r_q[8]; dst = 4'd7; end
        6'd7:  begin ma = tx0; mb = d2; dst = 4'd8; end
        6'd8:  begin ma = tx2; mb = d0; madd = r_q[8]; msub = 1'b1; dst = 4'd8; end
        6'd9:  begin ma = ty1; mb = r_q[8]; madd = r_q[7]; dst = 4'd7; end
        6'd10: begin ma = tx1; mb = d0; dst = 4'd8; end
        6'd11: begin ma = tx0; mb = d1; madd = r_q[8]; msub = 1'b1; dst = 4'd8; end
        6'd12: begin ma = ty2; mb = r_q[8]; madd = r_q[7]; dst = base + 4'd2; end
        default: wen = 1'b0;
      endcase
    end
  end

  assign prod  = {24'd0, ma} * {24'd0, mb};
  assign term  = mscl ? prod[55:24] : prod[31:0];
  assign acc_d = msub ? (madd - term) : (madd + term);

  always_ff @(posedge clk_i) begin
    if ((st_q == tpc_pkg::ST_MUL) && wen) r_q[dst] <= acc_d;
  end

  assign det_zero = (r_q[6] == 32'd0);
  always_comb begin
    num_sel = r_q[9];
    case (ci_q)
      3'd0: num_sel = r_q[9];
      3'd1: num_sel = r_q[10];
      3'd2: num_sel = r_q[11];
      3'd3: num_sel = r_q[12];
      3'd4: num_sel = r_q[13];
      3'd5: num_sel = r_q[14];
      default: num_sel = r_q[9];
    endcase
  end

  assign dreq.start    = (st_q == tpc_pkg::ST_DIVSTART);
  assign dreq.dividend = {{32{num_sel[31]}}, num_sel} << FRACTION_BITS;
  assign dreq.divisor  = r_q[6];

  tpc_div u_div (.clk_i(clk_i), .rst_ni(rst_ni), .req_i(dreq), .rsp_o(drsp));

  always_comb begin
    st_d = st_q; step_d = step_q; ci_d = ci_q;
    case (st_q)
      tpc_pkg::ST_IDLE: begin
        step_d = '0; ci_d = '0;
        if (accept && !pen_up_i && cnt_q == 2'd2) st_d = tpc_pkg::ST_MUL;
      end
      tpc_pkg::ST_MUL: begin
        step_d = step_q + 6'd1;
        if (step_q == tpc_pkg::LastStep) st_d = tpc_pkg::ST_DIVSTART;
      end
      tpc_pkg::ST_DIVSTART: st_d = det_zero ? tpc_pkg::ST_EMIT : tpc_pkg::ST_DIVWAIT;
      tpc_pkg::ST_DIVWAIT: if (drsp.done) st_d = tpc_pkg::ST_EMIT;
      tpc_pkg::ST_EMIT: begin
        ci_d = ci_q + 3'd1;
        st_d = (ci_q == 3'd5) ? tpc_pkg::ST_IDLE : tpc_pkg::ST_DIVSTART;
      end
      default: st_d = tpc_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= tpc_pkg::ST_IDLE; step_q <= '0; ci_q <= '0; cnt_q <= '0; out_v_q <= 1'b0;
    end else begin
      st_q <= st_d; step_q <= step_d; ci_q <= ci_d;
      if (accept && !pen_up_i) cnt_q <= (cnt_q == 2'd2) ? 2'd0 : cnt_q + 2'd1;
      out_v_q <= (st_q == tpc_pkg::ST_EMIT);
    end
  end

  always_ff @(posedge clk_i) begin
    if (st_q == tpc_pkg::ST_EMIT) begin
      out_idx_q <= ci_q;
      out_deg_q <= det_zero;
      out_val_q <= det_zero ? 32'd0 : drsp.quotient;
    end
  end

  assign valid_o      = out_v_q;
  assign coef_index_o = out_idx_q;
  assign coef_value_o = out_val_q;
  assign degenerate_o = out_deg_q;
  assign last_o       = out_v_q && (out_idx_q == 3'd5);

  cnt_range_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != 2'd3) else $error("sample count out of range");
  emit_idx_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> coef_index_o <= 3'd5) else $error("bad coefficient index");
  busy_out_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == tpc_pkg::ST_EMIT) |=> valid_o) else $error("emit lost");
endmodule

/* bench/tb_touch_three_point_calibration_top.sv */
`timescale 1ns / 1ps
module tb_touch_three_point_calibration_top;
  localparam int unsigned FracBits = tpc_pkg::FracBitsDefault;
  localparam int CycleLimit = 2000000;

  typedef struct {
    logic [2:0]  index;
    logic [31:0] value;
    logic        degen;
    logic        last;
  } coef_t;

  typedef struct {
    logic        pen_up;
    logic [9:0]  x;
    logic [9:0]  y;
    logic        has_exp;  // typed-in expectation for the coefficient A of a solve
    logic [31:0] exp_a;
    logic        exp_degen;
  } tap_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start_i = 1'b0;
  logic        busy_o;
  logic        pen_up_i = 1'b0;
  logic [9:0]  raw_x_i = '0;
  logic [9:0]  raw_y_i = '0;
  logic        cfg_we_i = 1'b0;
  logic [1:0]  cfg_index_i = tpc_pkg::REG_WIDTH;
  logic [10:0] cfg_data_i = '0;
  logic        valid_o;
  logic [2:0]  coef_index_o;
  logic signed [31:0] coef_value_o;
  logic        degenerate_o;
  logic        last_o;

  touch_three_point_calibration_top dut (.*);

  always #5 clk_i = ~clk_i;

  // calibration state mirror
  logic [31:0] scr_w, scr_h, off_h, off_v;
  logic [31:0] tap_x [3];
  logic [31:0] tap_y [3];
  int unsigned taps_held;
  coef_t coef_q[$];
  int mismatches;
  int cycles;
  logic [31:0] typed_a;
  logic        typed_degen;
  logic        typed_pending = 1'b0;

  function automatic logic [31:0] cross2(logic [31:0] a0, logic [31:0] a1,
                                         logic [31:0] b0, logic [31:0] b1);
    return a0 * b0 - a1 * b1;
  endfunction

  function automatic logic [31:0] offset_sum(logic [31:0] d [3]);
    return tap_y[0] * (tap_x[2] * d[1] - tap_x[1] * d[2])
         + tap_y[1] * (tap_x[0] * d[2] - tap_x[2] * d[0])
         + tap_y[2] * (tap_x[1] * d[0] - tap_x[0] * d[1]);
  endfunction

  task automatic solve_matrix();
    logic [31:0] dx [3];
    logic [31:0] dy [3];
    logic [31:0] num [6];
    logic signed [63:0] det, n, q;
    coef_t c;
    dx[0] = scr_w * 15 / 100 + off_h;
    dx[1] = scr_w * 85 / 100 + off_h;
    dx[2] = scr_w / 2 + off_h;
    dy[0] = scr_h * 15 / 100 + off_v;
    dy[1] = scr_h / 2 + off_v;
    dy[2] = scr_h * 85 / 100 + off_v;
    det = 64'(signed'(cross2(tap_x[0] - tap_x[2], tap_x[1] - tap_x[2],
                             tap_y[1] - tap_y[2], tap_y[0] - tap_y[2])));
    num[0] = cross2(dx[0] - dx[2], dx[1] - dx[2], tap_y[1] - tap_y[2], tap_y[0] - tap_y[2]);
    num[1] = cross2(tap_x[0] - tap_x[2], dx[0] - dx[2], dx[1] - dx[2], tap_x[1] - tap_x[2]);
    num[2] = offset_sum(dx);
    num[3] = cross2(dy[0] - dy[2], dy[1] - dy[2], tap_y[1] - tap_y[2], tap_y[0] - tap_y[2]);
    num[4] = cross2(tap_x[0] - tap_x[2], dy[0] - dy[2], dy[1] - dy[2], tap_x[1] - tap_x[2]);
    num[5] = offset_sum(dy);
    for (int i = 0; i < 6; i++) begin
      c.index = 3'(i);
      c.degen = (det == 0);
      c.last = (i == 5);
      c.value = '0;
      if (det != 0) begin
        n = 64'(signed'(num[i])) <<< FracBits;
        q = n / det;
        c.value = q[31:0];
      end
      coef_q.push_back(c);
    end
  endtask

  task automatic predict_tap(logic pen, logic [9:0] x, logic [9:0] y);
    if (pen) return;
    tap_x[taps_held] = 32'(x);
    tap_y[taps_held] = 32'(y);
    taps_held++;
    if (taps_held == 3) begin
      taps_held = 0;
      solve_matrix();
    end
  endtask

  // start_i stays high after a transfer; a gap or a drain drops it
  task automatic send_tap(logic pen, logic [9:0] x, logic [9:0] y, bit gaps);
    if (gaps && $urandom_range(0, 3) == 0) begin
      start_i <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk_i);
    end
    start_i <= 1'b1;
    pen_up_i <= pen;
    raw_x_i <= x;
    raw_y_i <= y;
    do @(posedge clk_i); while (busy_o);
    predict_tap(pen, x, y);
  endtask

  task automatic drain();
    start_i <= 1'b0;
    while (coef_q.size() != 0) @(posedge clk_i);
    // dropped pen-up readings never produce output, allow any tail work to settle
    repeat (500) @(posedge clk_i);
  endtask

  // cfg_we_i is dropped by the caller after the last write of a group
  task automatic write_reg(tpc_pkg::cfg_reg_e idx, logic [10:0] data);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    case (idx)
      tpc_pkg::REG_WIDTH:    scr_w = 32'(data);
      tpc_pkg::REG_HEIGHT:   scr_h = 32'(data);
      tpc_pkg::REG_HORZ_OFS: off_h = 32'(data);
      tpc_pkg::REG_VERT_OFS: off_v = 32'(data);
      default: ;
    endcase
  endtask

  // result checker
  always @(posedge clk_i) begin
    coef_t e;
    if (rst_ni && valid_o) begin
      if (coef_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected coefficient idx=%0d", coef_index_o);
      end else begin
        e = coef_q.pop_front();
        if (typed_pending && coef_index_o == 3'd0) begin
          if (e.value !== typed_a || e.degen !== typed_degen) begin
            mismatches++;
            if (mismatches <= 10)
              $display("typed A: exp %h/%b model %h/%b", typed_a, typed_degen, e.value, e.degen);
          end
        end
        if (coef_index_o !== e.index || coef_value_o !== e.value ||
            degenerate_o !== e.degen || last_o !== e.last) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp idx %0d val %h dg %b last %b, got %0d %h %b %b",
                     e.index, e.value, e.degen, e.last,
                     coef_index_o, coef_value_o, degenerate_o, last_o);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  tap_row_t taps [24];

  initial begin
    logic pen;
    int len;
    scr_w = 800; scr_h = 480; off_h = 0; off_v = 0;
    taps_held = 0;
    // corners and extremes; identical points give a zero determinant
    taps = '{
      '{0, 10'd0,    10'd0,    0, 0, 0}, '{1, 10'h3FF, 10'h3FF, 0, 0, 0},
      '{0, 10'd0,    10'd0,    0, 0, 0}, '{0, 10'd0,    10'd0,    1, 32'd0, 1},
      '{0, 10'h3FF, 10'h3FF, 0, 0, 0}, '{0, 10'h3FF, 10'h3FF, 0, 0, 0},
      '{0, 10'h3FF, 10'h3FF, 1, 32'd0, 1},
      '{0, 10'd0,    10'd0,    0, 0, 0}, '{0, 10'h3FF, 10'd0,    0, 0, 0},
      '{0, 10'd0,    10'h3FF, 0, 0, 0},
      '{0, 10'd150,  10'd100,  0, 0, 0}, '{0, 10'd850,  10'd500,  0, 0, 0},
      '{0, 10'd500,  10'd850,  0, 0, 0},
      '{1, 10'd0,    10'd0,    0, 0, 0}, '{0, 10'h2AA, 10'h155, 0, 0, 0},
      '{0, 10'h155, 10'h2AA, 0, 0, 0}, '{0, 10'd1,    10'd1,    0, 0, 0},
      '{0, 10'd0,    10'h3FF, 0, 0, 0}, '{0, 10'h3FF, 10'd0,    0, 0, 0},
      '{0, 10'd512,  10'd512,  0, 0, 0},
      '{0, 10'd100,  10'd200,  0, 0, 0}, '{0, 10'd300,  10'd600,  0, 0, 0},
      '{0, 10'd500,  10'd1000, 0, 0, 0},  // collinear
      '{1, 10'h3FF, 10'h3FF, 0, 0, 0}
    };
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (taps[i]) begin
      if (taps[i].has_exp) begin
        typed_a = taps[i].exp_a;
        typed_degen = taps[i].exp_degen;
        typed_pending = 1'b1;
      end
      send_tap(taps[i].pen_up, taps[i].x, taps[i].y, 1'b0);
      if (taps[i].has_exp) begin
        drain();
        typed_pending = 1'b0;
      end
    end
    drain();
    // random phases over several register settings, extremes included
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin write_reg(tpc_pkg::REG_WIDTH, 11'd1);
                 write_reg(tpc_pkg::REG_HEIGHT, 11'd1);
                 write_reg(tpc_pkg::REG_HORZ_OFS, 11'd0);
                 write_reg(tpc_pkg::REG_VERT_OFS, 11'd0); end
        1: begin write_reg(tpc_pkg::REG_WIDTH, 11'h7FF);
                 write_reg(tpc_pkg::REG_HEIGHT, 11'h7FF);
                 write_reg(tpc_pkg::REG_HORZ_OFS, 11'h7FF);
                 write_reg(tpc_pkg::REG_VERT_OFS, 11'h7FF); end
        2: begin write_reg(tpc_pkg::REG_WIDTH, 11'd0);
                 write_reg(tpc_pkg::REG_HEIGHT, 11'd0); end
        default: begin
          write_reg(tpc_pkg::REG_WIDTH, 11'($urandom_range(1, 2047)));
          write_reg(tpc_pkg::REG_HEIGHT, 11'($urandom_range(1, 2047)));
          write_reg(tpc_pkg::REG_HORZ_OFS, 11'($urandom));
          write_reg(tpc_pkg::REG_VERT_OFS, 11'($urandom));
        end
      endcase
      cfg_we_i <= 1'b0;
      len = 75;
      for (int k = 0; k < len; k++) begin
        pen = ($urandom_range(0, 9) == 0);
        send_tap(pen, 10'($urandom), 10'($urandom), ph < 5);
        if (ph == 3 && k == 30) drain();
      end
      drain();
    end
    drain();
    if (mismatches == 0 && coef_q.size() == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end
endmodule
